FILE: rtl/tcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcm_pkg
// Shared sizes and mode codes of the tensor contraction multiply-accumulate.
// ----------------------------------------------------------------------------
package tcm_pkg;

   localparam int DIM         = 8;
   localparam int OUTER_COUNT = DIM * DIM * DIM;
   localparam int STORE_DEPTH = OUTER_COUNT * DIM;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int K_W         = $clog2(DIM);

   localparam int MODE_W  = 2;
   localparam int INDEX_W = 9;
   localparam int INNER_W = 3;
   localparam int DATA_W  = 32;

   typedef logic [MODE_W-1:0] mode_type;

   localparam mode_type MODE_WRITE_LEFT  = 2'd0;
   localparam mode_type MODE_WRITE_RIGHT = 2'd1;
   localparam mode_type MODE_COMPUTE     = 2'd2;

endpackage

FILE: rtl/tensor_contraction_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tensor_contraction_mac
// Two element stores and a multiply-accumulate sequencer that returns one
// element of the contracted tensor product.
// ----------------------------------------------------------------------------
// Write words (left or right element) are taken without a stall and give no
// result. A compute word walks the shared inner index through both RAMs, one
// element pair per cycle, into a registered multiplier and accumulator: it
// keeps the input stalled until its sum is loaded into the output register.
// A compute whose row or column is out of range skips the walk and ends with
// a zero sum. A finished sum sits in the output register, so the next word is
// taken while it waits; the sequencer only stops when a second sum is ready
// and the first has not been taken.
module tensor_contraction_mac (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [tcm_pkg::MODE_W-1:0]         req_mode,
   input  logic [tcm_pkg::INDEX_W-1:0]        req_row,
   input  logic [tcm_pkg::INDEX_W-1:0]        req_col,
   input  logic [tcm_pkg::INNER_W-1:0]        req_inner,
   input  logic signed [tcm_pkg::DATA_W-1:0]  req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [tcm_pkg::DATA_W-1:0]  rsp_sum
);

   import tcm_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   state_type             state_ff, state_in;
   logic [K_W-1:0]        k_cnt_ff, k_cnt_in;
   logic [INDEX_W-1:0]    row_ff, row_in;
   logic [INDEX_W-1:0]    col_ff, col_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic                  rd_last_ff, rd_last_in;
   logic                  mul_vld_ff, mul_vld_in;
   logic                  mul_last_ff, mul_last_in;
   logic [DATA_W-1:0]     prod_ff, prod_in;
   logic [DATA_W-1:0]     acc_ff, acc_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]     rsp_sum_ff, rsp_sum_in;

   logic                  req_take;
   logic                  k_last;
   logic                  row_ok, col_ok, inner_ok;
   logic                  left_we, right_we;
   logic [STORE_AW-1:0]   left_waddr, right_waddr;
   logic [STORE_AW-1:0]   left_raddr, right_raddr;
   logic [DATA_W-1:0]     left_rdata, right_rdata;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   assign row_ok   = (int'(req_row) < OUTER_COUNT);
   assign col_ok   = (int'(req_col) < OUTER_COUNT);
   assign inner_ok = (int'(req_inner) < DIM);

   assign left_we  = req_take && (req_mode == MODE_WRITE_LEFT) && row_ok && inner_ok;
   assign right_we = req_take && (req_mode == MODE_WRITE_RIGHT) && col_ok && inner_ok;

   assign left_waddr  = STORE_AW'(int'(req_row) * DIM + int'(req_inner));
   assign right_waddr = STORE_AW'(int'(req_inner) * OUTER_COUNT + int'(req_col));
   assign left_raddr  = STORE_AW'(int'(row_ff) * DIM + int'(k_cnt_ff));
   assign right_raddr = STORE_AW'(int'(k_cnt_ff) * OUTER_COUNT + int'(col_ff));

   assign k_last = (k_cnt_ff == K_W'(DIM - 1));

   tcm_ram #(
      .DEPTH (STORE_DEPTH),
      .WIDTH (DATA_W)
   ) u_left_ram (
      .clock   (clock),
      .wr_en   (left_we),
      .wr_addr (left_waddr),
      .wr_data (DATA_W'(req_value)),
      .rd_addr (left_raddr),
      .rd_data (left_rdata)
   );

   tcm_ram #(
      .DEPTH (STORE_DEPTH),
      .WIDTH (DATA_W)
   ) u_right_ram (
      .clock   (clock),
      .wr_en   (right_we),
      .wr_addr (right_waddr),
      .wr_data (DATA_W'(req_value)),
      .rd_addr (right_raddr),
      .rd_data (right_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      k_cnt_in     = k_cnt_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_sum_in   = rsp_sum_ff;

      // read, multiply, accumulate pipeline
      rd_vld_in   = (state_ff == ST_RUN);
      rd_last_in  = (state_ff == ST_RUN) && k_last;
      mul_vld_in  = rd_vld_ff;
      mul_last_in = rd_last_ff;
      prod_in     = DATA_W'(left_rdata * right_rdata);
      if (mul_vld_ff) begin
         acc_in = acc_ff + prod_ff;
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_mode == MODE_COMPUTE)) begin
               row_in   = req_row;
               col_in   = req_col;
               k_cnt_in = '0;
               acc_in   = '0;
               state_in = (row_ok && col_ok) ? ST_RUN : ST_DONE;
            end
         end
         ST_RUN: begin
            k_cnt_in = k_cnt_ff + K_W'(1);
            if (k_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (mul_vld_ff && mul_last_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = acc_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_vld_ff    <= 1'b0;
         rd_last_ff   <= 1'b0;
         mul_vld_ff   <= 1'b0;
         mul_last_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         k_cnt_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         rd_last_ff   <= rd_last_in;
         mul_vld_ff   <= mul_vld_in;
         mul_last_ff  <= mul_last_in;
         rsp_valid_ff <= rsp_valid_in;
         k_cnt_ff     <= k_cnt_in;
      end
      row_ff     <= row_in;
      col_ff     <= col_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      rsp_sum_ff <= rsp_sum_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_sum   = signed'(rsp_sum_ff);

   // a compute word always keeps the input stalled on the next cycle
   a_compute_busy: assert property (@(posedge clock) disable iff (reset)
      req_take && (req_mode == MODE_COMPUTE) |=> req_stall)
      else $error("compute word did not start the sequencer");

   // products only flow while a dot product is in progress
   a_mul_in_walk: assert property (@(posedge clock) disable iff (reset)
      mul_vld_ff |-> (state_ff == ST_RUN) || (state_ff == ST_DRAIN))
      else $error("product outside of a dot product");

   // a new sum is only loaded from the done state
   a_load_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result loaded outside of done state");

   // a waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> $stable(rsp_sum_ff))
      else $error("pending result overwritten");

endmodule

FILE: rtl/tcm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcm_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tcm_ram #(
   parameter int DEPTH  = 4096,
   parameter int WIDTH  = 32,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: tb/tensor_contraction_mac_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tensor_contraction_mac_tb
// Self-checking bench for the tensor contraction multiply-accumulate. A short
// table of words exercises extreme values, the unused mode and product
// wraparound. Random bursts then fill whole left rows and right columns and
// contract them. Sums are checked against a model of both stores or the table.
// Both sides idle at random, and the result side holds off for long stretches.
// ----------------------------------------------------------------------------
module tensor_contraction_mac_tb;

   import tcm_pkg::*;

   localparam mode_type MODE_UNUSED    = 2'd3;
   localparam int       RANDOM_ITEMS   = 1050;
   localparam int       DRAIN_CYCLES   = 2 * DIM + 8;
   localparam int       LONG_HOLD      = 400;
   localparam int       DIRECTED_COUNT = 24;

   typedef struct packed {
      mode_type            mode;
      logic [INDEX_W-1:0]  row;
      logic [INDEX_W-1:0]  col;
      logic [INNER_W-1:0]  inner;
      logic [DATA_W-1:0]   value;
      logic                known;
      logic [DATA_W-1:0]   known_sum;
   } tensor_word_type;

   // left row 511 and right column 511: (-2^31)^2, (2^31-1)^2, (-1)^2, then zeros
   localparam tensor_word_type DIRECTED [DIRECTED_COUNT] = '{
      '{MODE_WRITE_LEFT,  9'd511, 9'd0,   3'd0, 32'h8000_0000, 1'b0, 32'd0},
      '{MODE_WRITE_LEFT,  9'd511, 9'd0,   3'd1, 32'h7FFF_FFFF, 1'b0, 32'd0},
      '{MODE_WRITE_LEFT,  9'd511, 9'd0,   3'd2, 32'hFFFF_FFFF, 1'b0, 32'd0},
      '{MODE_WRITE_LEFT,  9'd511, 9'd0,   3'd3, 32'h0000_0000, 1'b0, 32'd0},
      '{MODE_WRITE_LEFT,  9'd511, 9'd0,   3'd4, 32'h0000_0000, 1'b0, 32'd0},
      '{MODE_WRITE_LEFT,  9'd511, 9'd0,   3'd5, 32'h0000_0000, 1'b0, 32'd0},
      '{MODE_WRITE_LEFT,  9'd511, 9'd0,   3'd6, 32'h0000_0000, 1'b0, 32'd0},
      '{MODE_WRITE_LEFT,  9'd511, 9'd0,   3'd7, 32'h0000_0000, 1'b0, 32'd0},
      '{MODE_WRITE_RIGHT, 9'd0,   9'd511, 3'd0, 32'h8000_0000, 1'b0, 32'd0},
      '{MODE_WRITE_RIGHT, 9'd0,   9'd511, 3'd1, 32'h7FFF_FFFF, 1'b0, 32'd0},
      '{MODE_WRITE_RIGHT, 9'd0,   9'd511, 3'd2, 32'hFFFF_FFFF, 1'b0, 32'd0},
      '{MODE_WRITE_RIGHT, 9'd0,   9'd511, 3'd3, 32'h0000_0000, 1'b0, 32'd0},
      '{MODE_WRITE_RIGHT, 9'd0,   9'd511, 3'd4, 32'h0000_0000, 1'b0, 32'd0},
      '{MODE_WRITE_RIGHT, 9'd0,   9'd511, 3'd5, 32'h0000_0000, 1'b0, 32'd0},
      '{MODE_WRITE_RIGHT, 9'd0,   9'd511, 3'd6, 32'h0000_0000, 1'b0, 32'd0},
      '{MODE_WRITE_RIGHT, 9'd0,   9'd511, 3'd7, 32'h0000_0000, 1'b0, 32'd0},
      '{MODE_COMPUTE,     9'd511, 9'd511, 3'd0, 32'h0000_0000, 1'b1, 32'd2},
      '{MODE_UNUSED,      9'd511, 9'd511, 3'd7, 32'hFFFF_FFFF, 1'b0, 32'd0},
      '{MODE_COMPUTE,     9'd511, 9'd511, 3'd7, 32'hFFFF_FFFF, 1'b1, 32'd2},
      '{MODE_WRITE_LEFT,  9'd511, 9'd0,   3'd7, 32'h0000_0003, 1'b0, 32'd0},
      '{MODE_WRITE_RIGHT, 9'd0,   9'd511, 3'd7, 32'hFFFF_FFFE, 1'b0, 32'd0},
      '{MODE_COMPUTE,     9'd511, 9'd511, 3'd0, 32'h0000_0000, 1'b1, 32'hFFFF_FFFC},
      '{MODE_UNUSED,      9'd0,   9'd0,   3'd0, 32'h0000_0000, 1'b0, 32'd0},
      '{MODE_COMPUTE,     9'd511, 9'd511, 3'd0, 32'h0000_0000, 1'b1, 32'hFFFF_FFFC}
   };

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid;
   logic                      req_stall;
   logic [MODE_W-1:0]         req_mode;
   logic [INDEX_W-1:0]        req_row;
   logic [INDEX_W-1:0]        req_col;
   logic [INNER_W-1:0]        req_inner;
   logic signed [DATA_W-1:0]  req_value;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic signed [DATA_W-1:0]  rsp_sum;

   logic [DATA_W-1:0]         left_mem  [STORE_DEPTH];
   logic [DATA_W-1:0]         right_mem [STORE_DEPTH];
   logic [DIM-1:0]            left_done [OUTER_COUNT];
   logic [DIM-1:0]            right_done [OUTER_COUNT];
   int                        full_rows [$];
   int                        full_cols [$];
   logic signed [DATA_W-1:0]  pending_sums [$];

   int   failures      = 0;
   int   words_sent    = 0;
   int   words_offered = 0;
   int   sums_taken    = 0;
   bit   req_idling    = 1'b0;
   bit   rsp_idling    = 1'b0;

   tensor_contraction_mac dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_mode  (req_mode),
      .req_row   (req_row),
      .req_col   (req_col),
      .req_inner (req_inner),
      .req_value (req_value),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_sum   (rsp_sum)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      for (int i = 0; i < OUTER_COUNT; i++) begin
         left_done[i]  = '0;
         right_done[i] = '0;
      end
   end

   function automatic logic [DATA_W-1:0] contract(int r, int c);
      logic [DATA_W-1:0] acc;
      acc = '0;
      for (int k = 0; k < DIM; k++) begin
         acc = acc + left_mem[r * DIM + k] * right_mem[k * OUTER_COUNT + c];
      end
      return acc;
   endfunction

   function automatic void apply_word(tensor_word_type w);
      int r;
      int c;
      int k;
      r = w.row;
      c = w.col;
      k = w.inner;
      case (w.mode)
         MODE_WRITE_LEFT: begin
            if (r < OUTER_COUNT && k < DIM) begin
               left_mem[r * DIM + k] = w.value;
               if (left_done[r] != '1) begin
                  left_done[r][k] = 1'b1;
                  if (left_done[r] == '1) full_rows.push_back(r);
               end
            end
         end
         MODE_WRITE_RIGHT: begin
            if (c < OUTER_COUNT && k < DIM) begin
               right_mem[k * OUTER_COUNT + c] = w.value;
               if (right_done[c] != '1) begin
                  right_done[c][k] = 1'b1;
                  if (right_done[c] == '1) full_cols.push_back(c);
               end
            end
         end
         MODE_COMPUTE: begin
            if (w.known) begin
               pending_sums.push_back(w.known_sum);
            end else if (r < OUTER_COUNT && c < OUTER_COUNT) begin
               pending_sums.push_back(contract(r, c));
            end else begin
               pending_sums.push_back('0);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic tensor_word_type pack_word(mode_type mode, int row, int col, int inner,
                                                 logic [DATA_W-1:0] value);
      tensor_word_type w;
      w.mode      = mode;
      w.row       = row[INDEX_W-1:0];
      w.col       = col[INDEX_W-1:0];
      w.inner     = inner[INNER_W-1:0];
      w.value     = value;
      w.known     = 1'b0;
      w.known_sum = '0;
      return w;
   endfunction

   function automatic logic [DATA_W-1:0] draw_value();
      case ($urandom_range(0, 4))
         0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         1: return 32'($urandom_range(0, 16)) - 32'd8;
         default: return $urandom;
      endcase
   endfunction

   // called right after a rising edge; returns at the edge that takes the word
   task automatic send_word(tensor_word_type w);
      int gap;
      if (words_offered % 40 == 0) req_idling = $urandom_range(0, 1);
      words_offered++;
      gap = req_idling ? $urandom_range(0, 4) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= w.mode;
      req_row   <= w.row;
      req_col   <= w.col;
      req_inner <= w.inner;
      req_value <= w.value;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      apply_word(w);
      if (w.mode != MODE_UNUSED) words_sent++;
   endtask

   task automatic send_full_compute();
      send_word(pack_word(MODE_COMPUTE,
                          full_rows[$urandom_range(0, full_rows.size() - 1)],
                          full_cols[$urandom_range(0, full_cols.size() - 1)],
                          $urandom_range(0, DIM - 1), draw_value()));
   endtask

   task automatic send_noise();
      case ($urandom_range(0, 11))
         0: send_word(pack_word(MODE_UNUSED, $urandom_range(0, OUTER_COUNT - 1),
                                $urandom_range(0, OUTER_COUNT - 1),
                                $urandom_range(0, DIM - 1), draw_value()));
         1: send_word(pack_word(mode_type'($urandom_range(0, 1)),
                                $urandom_range(0, OUTER_COUNT - 1),
                                $urandom_range(0, OUTER_COUNT - 1),
                                $urandom_range(0, DIM - 1), draw_value()));
         2: send_full_compute();
         default: ;
      endcase
   endtask

   initial begin
      int r;
      int c;
      int left_perm;
      int right_perm;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_mode  <= MODE_WRITE_LEFT;
      req_row   <= '0;
      req_col   <= '0;
      req_inner <= '0;
      req_value <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_COUNT; i++) send_word(DIRECTED[i]);

      while (words_sent < DIRECTED_COUNT + RANDOM_ITEMS) begin
         r          = $urandom_range(0, OUTER_COUNT - 1);
         c          = $urandom_range(0, OUTER_COUNT - 1);
         left_perm  = $urandom_range(0, DIM - 1);
         right_perm = $urandom_range(0, DIM - 1);
         for (int k = 0; k < DIM; k++) begin
            send_noise();
            send_word(pack_word(MODE_WRITE_LEFT, r, $urandom_range(0, OUTER_COUNT - 1),
                                k ^ left_perm, draw_value()));
         end
         for (int k = 0; k < DIM; k++) begin
            send_noise();
            send_word(pack_word(MODE_WRITE_RIGHT, $urandom_range(0, OUTER_COUNT - 1), c,
                                k ^ right_perm, draw_value()));
         end
         send_word(pack_word(MODE_COMPUTE, r, c, $urandom_range(0, DIM - 1), draw_value()));
         repeat ($urandom_range(0, 2)) send_full_compute();
      end
      req_valid <= 1'b0;

      while (pending_sums.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // result side: random stalls per word, two long hold-offs to back up the block
   initial begin
      int                       hold;
      logic signed [DATA_W-1:0] want;
      rsp_stall <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (sums_taken % 15 == 0) rsp_idling = $urandom_range(0, 1);
         hold = rsp_idling ? $urandom_range(0, 4) : 0;
         if (sums_taken == 25 || sums_taken == 90) hold = LONG_HOLD;
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         if (pending_sums.size() == 0) begin
            $error("sum: expected nothing, actual %0d", rsp_sum);
            failures++;
         end else begin
            want = pending_sums.pop_front();
            if (rsp_sum !== want) begin
               $error("sum: expected %0d, actual %0d", want, rsp_sum);
               failures++;
            end
         end
         sums_taken++;
      end
   end

   initial begin
      #1_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
